// ===== rtl/sparse_group_shrink_prox_core_defines.svh =====
// ----------------------------------------------------------------------------
// sparse_group_shrink_prox_core_defines
// Assertion macros used by the sparse group shrink controller RTL.
// ----------------------------------------------------------------------------
`ifndef SPARSE_GROUP_SHRINK_PROX_CORE_DEFINES_SVH
`define SPARSE_GROUP_SHRINK_PROX_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SGSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SGSP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sgsp_pkg.sv =====
// ----------------------------------------------------------------------------
// sgsp_pkg
// Types and constants shared by the sparse group shrink controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sgsp_pkg;

    localparam int DEF_MAX_LEN    = 1024;
    localparam int DEF_MAX_GROUPS = 256;

    localparam int DATA_W  = 32;
    localparam int INDEX_W = 10;
    localparam int GPOS_W  = 11;
    localparam int CFG_A_W = 2;
    localparam int STEP_W  = 5;

    // 32 iterations for both the square root and the divider
    localparam logic [STEP_W-1:0] STEP_LAST = 5'd31;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_L1_MODE   = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_L1_THRESH = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_GRP_COUNT = 2'd2;
    localparam logic [CFG_A_W-1:0] CFG_VEC_LEN   = 2'd3;

    typedef enum logic [1:0] {
        KIND_LOAD_GROUP = 2'd0,
        KIND_WRITE_ELEM = 2'd1,
        KIND_RUN        = 2'd2,
        KIND_READ_ELEM  = 2'd3
    } t_kind;

    typedef enum logic [4:0] {
        S_IDLE, S_RD_OUT, S_L1_RD, S_L1_WR, S_GRP_RD, S_GRP_SET,
        S_SQ_RD, S_SQ_MUL, S_SQ_ACC, S_SQRT, S_DEC,
        S_SC_RD, S_SC_MUL, S_SC_DIV, S_SC_WR, S_FIN
    } t_state;

    typedef enum logic [4:0] {
        OP_NOP, OP_LD_GRP, OP_WR_ELEM, OP_START, OP_RD_IN, OP_OUT_RD,
        OP_VEC_RD, OP_L1_WR, OP_GRP_RD, OP_GRP_SET, OP_SQ_MUL, OP_SQ_ACC,
        OP_SQRT_INIT, OP_SQRT_STEP, OP_DEC, OP_SC_MUL, OP_DIV_STEP,
        OP_SC_WR, OP_G_NEXT, OP_OUT_RUN
    } t_dp_op;

    typedef struct packed {
        logic l1_on;   // soft threshold pass enabled
        logic j_end;   // element walk reached its bound
        logic g_end;   // all groups processed
        logic shrink;  // norm above weight for current group
    } t_dp_status;

endpackage

// ===== rtl/sgsp_dp.sv =====
// ----------------------------------------------------------------------------
// sgsp_dp
// Datapath: config registers, vector and group memories, multiplier,
// square root and divider iterations, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgsp_dp #(
    parameter int MAX_LEN    = sgsp_pkg::DEF_MAX_LEN,
    parameter int MAX_GROUPS = sgsp_pkg::DEF_MAX_GROUPS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sgsp_pkg::t_dp_op                    i_op,
    output sgsp_pkg::t_dp_status                o_status,
    input  logic                                i_cfg_we,
    input  logic [sgsp_pkg::CFG_A_W-1:0]        i_cfg_addr,
    input  logic [sgsp_pkg::DATA_W-1:0]         i_cfg_data,
    input  logic [sgsp_pkg::INDEX_W-1:0]        i_index,
    input  logic signed [sgsp_pkg::DATA_W-1:0]  i_value,
    input  logic [sgsp_pkg::GPOS_W-1:0]         i_group_start,
    input  logic [sgsp_pkg::GPOS_W-1:0]         i_group_end,
    input  logic [sgsp_pkg::DATA_W-1:0]         i_group_weight,
    output logic signed [sgsp_pkg::DATA_W-1:0]  o_out_value,
    output logic [sgsp_pkg::INDEX_W-1:0]        o_out_index,
    output logic                                o_run_done
);

    localparam int AW   = $clog2(MAX_LEN);
    localparam int GW   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int GCW  = $clog2(MAX_GROUPS + 1);
    localparam int LW   = $clog2(MAX_LEN + 1);
    localparam int JW   = (LW > sgsp_pkg::GPOS_W) ? LW : sgsp_pkg::GPOS_W;
    localparam int DW   = sgsp_pkg::DATA_W;
    localparam int PW   = sgsp_pkg::GPOS_W;
    localparam int GDW  = 2 * PW + DW;

    // configuration
    logic          r_l1_mode;
    logic [DW-1:0] r_l1_thr;
    logic [8:0]    r_gcount;
    logic [10:0]   r_vlen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1_mode <= 1'b0;
            r_l1_thr  <= '0;
            r_gcount  <= '0;
            r_vlen    <= 11'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sgsp_pkg::CFG_L1_MODE:   r_l1_mode <= i_cfg_data[0];
                sgsp_pkg::CFG_L1_THRESH: r_l1_thr  <= i_cfg_data;
                sgsp_pkg::CFG_GRP_COUNT: r_gcount  <= i_cfg_data[8:0];
                sgsp_pkg::CFG_VEC_LEN:   r_vlen    <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // effective length and group count
    logic [JW-1:0]  len_j;
    logic [GCW-1:0] cnt_g;
    assign len_j = (32'(r_vlen) < 32'(MAX_LEN)) ? JW'(r_vlen) : JW'(MAX_LEN);
    assign cnt_g = (32'(r_gcount) < 32'(MAX_GROUPS)) ? GCW'(r_gcount) : GCW'(MAX_GROUPS);

    // input index decode
    logic [31:0]   idx32;
    logic          idx_vec_ok;
    logic          idx_grp_ok;
    logic [AW-1:0] idx_vaddr;
    logic [GW-1:0] idx_gaddr;
    assign idx32      = 32'(i_index);
    assign idx_vec_ok = idx32 < 32'(MAX_LEN);
    assign idx_grp_ok = idx32 < 32'(MAX_GROUPS);
    assign idx_vaddr  = idx32[AW-1:0];
    assign idx_gaddr  = idx32[GW-1:0];

    // walk registers
    logic [JW-1:0]  r_j, r_lo, r_hi;
    logic [GCW-1:0] r_g;

    // group table memory
    logic [GDW-1:0] r_gmem [MAX_GROUPS];
    logic [GDW-1:0] r_gdata;

    always_ff @(posedge i_clk) begin
        if (i_op == sgsp_pkg::OP_LD_GRP && idx_grp_ok) begin
            r_gmem[idx_gaddr] <= {i_group_start, i_group_end, i_group_weight};
        end
        r_gdata <= r_gmem[r_g[GW-1:0]];
    end

    logic [PW-1:0] g_start, g_end;
    logic [DW-1:0] g_weight;
    assign {g_start, g_end, g_weight} = r_gdata;

    // vector memory, one write and one registered read port
    logic [DW-1:0] r_vmem [MAX_LEN];
    logic [DW-1:0] r_rdata;
    logic          vec_we;
    logic [AW-1:0] vec_waddr;
    logic [DW-1:0] vec_wdata;
    logic [AW-1:0] vec_raddr;

    always_ff @(posedge i_clk) begin
        if (vec_we) begin
            r_vmem[vec_waddr] <= vec_wdata;
        end
        r_rdata <= r_vmem[vec_raddr];
    end

    assign vec_raddr = (i_op == sgsp_pkg::OP_RD_IN) ? idx_vaddr : r_j[AW-1:0];

    // soft threshold of the word just read
    logic signed [DW+1:0] thr_v, thr_t, thr_r;
    always_comb begin
        thr_v = (DW+2)'(signed'(r_rdata));
        thr_t = signed'({2'b00, r_l1_thr});
        if (thr_v > thr_t) begin
            thr_r = thr_v - thr_t;
        end else if (thr_v < -thr_t) begin
            thr_r = thr_v + thr_t;
        end else begin
            thr_r = '0;
        end
    end

    // magnitude of the word just read
    logic          rd_neg;
    logic [DW-1:0] rd_mag;
    assign rd_neg = r_rdata[DW-1];
    assign rd_mag = rd_neg ? (DW'(0) - r_rdata) : r_rdata;

    // arithmetic registers
    logic [2*DW-1:0] r_sq, r_sum;
    logic [2*DW-1:0] r_sa, r_sres, r_sbit;
    logic [DW-1:0]   r_diff, r_rem, r_quo;
    logic            r_neg, r_shrink;

    logic [2*DW:0]   acc_sum;
    logic [2*DW-1:0] sq_trial;
    logic [DW-1:0]   norm;
    logic [DW:0]     div_t;
    logic            div_ge;
    logic [DW-1:0]   sc_val;

    assign acc_sum  = {1'b0, r_sum} + {1'b0, r_sq};
    assign sq_trial = r_sres + r_sbit;
    assign norm     = r_sres[DW-1:0];
    assign div_t    = {r_rem, r_quo[DW-1]};
    assign div_ge   = div_t >= {1'b0, norm};
    assign sc_val   = r_neg ? (DW'(0) - r_quo) : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            case (i_op)
                sgsp_pkg::OP_GRP_SET: r_sum <= '0;
                sgsp_pkg::OP_SQ_ACC:  r_sum <= acc_sum[2*DW] ? '1 : acc_sum[2*DW-1:0];
                default: ;
            endcase
        end
    end

    // walk counters, multiplier, square root and divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j <= '0;
            r_g <= '0;
        end else begin
            case (i_op)
                sgsp_pkg::OP_START: begin
                    r_j <= '0;
                    r_hi <= len_j;
                    r_g <= '0;
                end
                sgsp_pkg::OP_L1_WR, sgsp_pkg::OP_SQ_ACC, sgsp_pkg::OP_SC_WR: begin
                    r_j <= r_j + 1'b1;
                end
                sgsp_pkg::OP_GRP_SET: begin
                    r_lo <= (g_start == '0) ? '0 : JW'(g_start - 1'b1);
                    r_j  <= (g_start == '0) ? '0 : JW'(g_start - 1'b1);
                    r_hi <= (JW'(g_end) < len_j) ? JW'(g_end) : len_j;
                end
                sgsp_pkg::OP_SQ_MUL: begin
                    r_sq <= rd_mag * rd_mag;
                end
                sgsp_pkg::OP_SQRT_INIT: begin
                    r_sa   <= r_sum;
                    r_sres <= '0;
                    r_sbit <= (2*DW)'(1) << (2*DW - 2);
                end
                sgsp_pkg::OP_SQRT_STEP: begin
                    if (r_sa >= sq_trial) begin
                        r_sa   <= r_sa - sq_trial;
                        r_sres <= (r_sres >> 1) + r_sbit;
                    end else begin
                        r_sres <= r_sres >> 1;
                    end
                    r_sbit <= r_sbit >> 2;
                end
                sgsp_pkg::OP_DEC: begin
                    r_shrink <= norm > g_weight;
                    r_diff   <= norm - g_weight;
                    r_j      <= r_lo;
                end
                sgsp_pkg::OP_SC_MUL: begin
                    if (r_shrink) begin
                        {r_rem, r_quo} <= rd_mag * r_diff;
                        r_neg <= rd_neg;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                sgsp_pkg::OP_DIV_STEP: begin
                    r_rem <= div_ge ? DW'(div_t - {1'b0, norm}) : div_t[DW-1:0];
                    r_quo <= {r_quo[DW-2:0], div_ge};
                end
                sgsp_pkg::OP_G_NEXT: begin
                    r_g <= r_g + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // vector write port select
    always_comb begin
        vec_we    = 1'b0;
        vec_waddr = r_j[AW-1:0];
        vec_wdata = r_rdata;
        case (i_op)
            sgsp_pkg::OP_WR_ELEM: begin
                vec_we    = idx_vec_ok;
                vec_waddr = idx_vaddr;
                vec_wdata = i_value;
            end
            sgsp_pkg::OP_L1_WR: begin
                vec_we    = 1'b1;
                vec_wdata = thr_r[DW-1:0];
            end
            sgsp_pkg::OP_SC_MUL: begin
                vec_we    = !r_shrink;
                vec_wdata = '0;
            end
            sgsp_pkg::OP_SC_WR: begin
                vec_we    = 1'b1;
                vec_wdata = sc_val;
            end
            default: ;
        endcase
    end

    // read-back capture and result register
    localparam int INDEX_WIDTH_FIX = sgsp_pkg::INDEX_W;
    logic [INDEX_WIDTH_FIX-1:0] r_rd_idx;
    logic                       r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_op == sgsp_pkg::OP_RD_IN) begin
            r_rd_idx <= i_index;
            r_rd_ok  <= idx_vec_ok;
        end
        case (i_op)
            sgsp_pkg::OP_OUT_RD: begin
                o_out_value <= r_rd_ok ? signed'(r_rdata) : '0;
                o_out_index <= r_rd_idx;
                o_run_done  <= 1'b0;
            end
            sgsp_pkg::OP_OUT_RUN: begin
                o_out_value <= '0;
                o_out_index <= '0;
                o_run_done  <= 1'b1;
            end
            default: ;
        endcase
    end

    // status to controller
    assign o_status.l1_on  = r_l1_mode;
    assign o_status.j_end  = r_j >= r_hi;
    assign o_status.g_end  = r_g >= cnt_g;
    assign o_status.shrink = r_shrink;

endmodule

// ===== rtl/sgsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// sgsp_ctrl
// Controller: input and output handshakes and the run sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sparse_group_shrink_prox_core_defines.svh"

module sgsp_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_kind,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  sgsp_pkg::t_dp_status i_status,
    output sgsp_pkg::t_dp_op     o_op
);

    sgsp_pkg::t_state              r_state, n_state;
    logic [sgsp_pkg::STEP_W-1:0]   r_step, n_step;
    logic                          r_out_valid;
    logic                          out_free;
    logic                          in_acc;
    sgsp_pkg::t_kind               kind;

    assign kind        = sgsp_pkg::t_kind'(i_kind);
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == sgsp_pkg::S_IDLE) && out_free;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = '0;
        unique case (r_state)
            sgsp_pkg::S_IDLE: begin
                if (in_acc) begin
                    unique case (kind)
                        sgsp_pkg::KIND_RUN:
                            n_state = i_status.l1_on ? sgsp_pkg::S_L1_RD : sgsp_pkg::S_GRP_RD;
                        sgsp_pkg::KIND_READ_ELEM: n_state = sgsp_pkg::S_RD_OUT;
                        default: n_state = sgsp_pkg::S_IDLE;
                    endcase
                end
            end
            sgsp_pkg::S_RD_OUT:  n_state = sgsp_pkg::S_IDLE;
            sgsp_pkg::S_L1_RD:
                n_state = i_status.j_end ? sgsp_pkg::S_GRP_RD : sgsp_pkg::S_L1_WR;
            sgsp_pkg::S_L1_WR:   n_state = sgsp_pkg::S_L1_RD;
            sgsp_pkg::S_GRP_RD:
                n_state = i_status.g_end ? sgsp_pkg::S_FIN : sgsp_pkg::S_GRP_SET;
            sgsp_pkg::S_GRP_SET: n_state = sgsp_pkg::S_SQ_RD;
            sgsp_pkg::S_SQ_RD:
                n_state = i_status.j_end ? sgsp_pkg::S_SQRT : sgsp_pkg::S_SQ_MUL;
            sgsp_pkg::S_SQ_MUL:  n_state = sgsp_pkg::S_SQ_ACC;
            sgsp_pkg::S_SQ_ACC:  n_state = sgsp_pkg::S_SQ_RD;
            sgsp_pkg::S_SQRT: begin
                n_step = r_step + 1'b1;
                if (r_step == sgsp_pkg::STEP_LAST) begin
                    n_state = sgsp_pkg::S_DEC;
                end
            end
            sgsp_pkg::S_DEC:     n_state = sgsp_pkg::S_SC_RD;
            sgsp_pkg::S_SC_RD:
                n_state = i_status.j_end ? sgsp_pkg::S_GRP_RD : sgsp_pkg::S_SC_MUL;
            sgsp_pkg::S_SC_MUL:
                n_state = i_status.shrink ? sgsp_pkg::S_SC_DIV : sgsp_pkg::S_SC_RD;
            sgsp_pkg::S_SC_DIV: begin
                n_step = r_step + 1'b1;
                if (r_step == sgsp_pkg::STEP_LAST) begin
                    n_state = sgsp_pkg::S_SC_WR;
                end
            end
            sgsp_pkg::S_SC_WR:   n_state = sgsp_pkg::S_SC_RD;
            sgsp_pkg::S_FIN:
                if (out_free) begin
                    n_state = sgsp_pkg::S_IDLE;
                end
            default:             n_state = sgsp_pkg::S_IDLE;
        endcase
    end

    // datapath command
    always_comb begin
        o_op = sgsp_pkg::OP_NOP;
        unique case (r_state)
            sgsp_pkg::S_IDLE: begin
                if (in_acc) begin
                    unique case (kind)
                        sgsp_pkg::KIND_LOAD_GROUP: o_op = sgsp_pkg::OP_LD_GRP;
                        sgsp_pkg::KIND_WRITE_ELEM: o_op = sgsp_pkg::OP_WR_ELEM;
                        sgsp_pkg::KIND_RUN:        o_op = sgsp_pkg::OP_START;
                        sgsp_pkg::KIND_READ_ELEM:  o_op = sgsp_pkg::OP_RD_IN;
                        default:                   o_op = sgsp_pkg::OP_NOP;
                    endcase
                end
            end
            sgsp_pkg::S_RD_OUT:  o_op = sgsp_pkg::OP_OUT_RD;
            sgsp_pkg::S_L1_RD:
                o_op = i_status.j_end ? sgsp_pkg::OP_NOP : sgsp_pkg::OP_VEC_RD;
            sgsp_pkg::S_L1_WR:   o_op = sgsp_pkg::OP_L1_WR;
            sgsp_pkg::S_GRP_RD:
                o_op = i_status.g_end ? sgsp_pkg::OP_NOP : sgsp_pkg::OP_GRP_RD;
            sgsp_pkg::S_GRP_SET: o_op = sgsp_pkg::OP_GRP_SET;
            sgsp_pkg::S_SQ_RD:
                o_op = i_status.j_end ? sgsp_pkg::OP_SQRT_INIT : sgsp_pkg::OP_VEC_RD;
            sgsp_pkg::S_SQ_MUL:  o_op = sgsp_pkg::OP_SQ_MUL;
            sgsp_pkg::S_SQ_ACC:  o_op = sgsp_pkg::OP_SQ_ACC;
            sgsp_pkg::S_SQRT:    o_op = sgsp_pkg::OP_SQRT_STEP;
            sgsp_pkg::S_DEC:     o_op = sgsp_pkg::OP_DEC;
            sgsp_pkg::S_SC_RD:
                o_op = i_status.j_end ? sgsp_pkg::OP_G_NEXT : sgsp_pkg::OP_VEC_RD;
            sgsp_pkg::S_SC_MUL:  o_op = sgsp_pkg::OP_SC_MUL;
            sgsp_pkg::S_SC_DIV:  o_op = sgsp_pkg::OP_DIV_STEP;
            sgsp_pkg::S_SC_WR:   o_op = sgsp_pkg::OP_SC_WR;
            sgsp_pkg::S_FIN:
                o_op = out_free ? sgsp_pkg::OP_OUT_RUN : sgsp_pkg::OP_NOP;
            default:             o_op = sgsp_pkg::OP_NOP;
        endcase
    end

    // state, step counter and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sgsp_pkg::S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (o_op == sgsp_pkg::OP_OUT_RD || o_op == sgsp_pkg::OP_OUT_RUN) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `SGSP_ASSERT_IMP(a_ready_in_idle, i_clk, i_rst_n, o_in_ready, r_state == sgsp_pkg::S_IDLE, "input ready outside idle")
    `SGSP_ASSERT_NXT(a_run_leaves_idle, i_clk, i_rst_n, in_acc && kind == sgsp_pkg::KIND_RUN, r_state != sgsp_pkg::S_IDLE, "run word did not start sequencer")
    `SGSP_ASSERT_NXT(a_sqrt_length, i_clk, i_rst_n, r_state == sgsp_pkg::S_SQRT && r_step == sgsp_pkg::STEP_LAST, r_state == sgsp_pkg::S_DEC, "square root did not end after 32 steps")
    `SGSP_ASSERT_NXT(a_run_result, i_clk, i_rst_n, r_state == sgsp_pkg::S_FIN && out_free, r_out_valid && r_state == sgsp_pkg::S_IDLE, "run result not posted")

endmodule

// ===== rtl/sparse_group_shrink_prox_core.sv =====
// ----------------------------------------------------------------------------
// sparse_group_shrink_prox_core
// Sparse group lasso proximal step over a stored Q16.16 vector.
// ----------------------------------------------------------------------------
// Group load and element write words are taken in idle and can arrive
// back to back while no earlier result is waiting; an element read passes
// through the registered memory read, then the result register. A run word
// is worked by one sequencer over the vector memory with its one write and
// one registered read port: the soft-threshold pass, when enabled, reads
// and writes each element and then ends the walk; then each group takes a
// table read and setup, a sum of squares, a 32-step square root, the
// decision and a scale walk, in which each element is either zeroed or
// scaled (multiply, then a 32-step divider). After the end of the group
// table the run result is posted, waiting while the result register is still
// held. New words are refused until a run or read has posted its result.
// The memories need no clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sparse_group_shrink_prox_core #(
    parameter int MAX_LEN    = sgsp_pkg::DEF_MAX_LEN,
    parameter int MAX_GROUPS = sgsp_pkg::DEF_MAX_GROUPS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sgsp_pkg::CFG_A_W-1:0]        i_cfg_addr,
    input  logic [sgsp_pkg::DATA_W-1:0]         i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_kind,
    input  logic [sgsp_pkg::INDEX_W-1:0]        i_index,
    input  logic signed [sgsp_pkg::DATA_W-1:0]  i_value,
    input  logic [sgsp_pkg::GPOS_W-1:0]         i_group_start,
    input  logic [sgsp_pkg::GPOS_W-1:0]         i_group_end,
    input  logic [sgsp_pkg::DATA_W-1:0]         i_group_weight,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [sgsp_pkg::DATA_W-1:0]  o_out_value,
    output logic [sgsp_pkg::INDEX_W-1:0]        o_out_index,
    output logic                                o_run_done
);

    sgsp_pkg::t_dp_op     op;
    sgsp_pkg::t_dp_status status;

    // sequencer
    sgsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_op        (op)
    );

    // storage and arithmetic
    sgsp_dp #(
        .MAX_LEN    (MAX_LEN),
        .MAX_GROUPS (MAX_GROUPS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_index        (i_index),
        .i_value        (i_value),
        .i_group_start  (i_group_start),
        .i_group_end    (i_group_end),
        .i_group_weight (i_group_weight),
        .o_out_value    (o_out_value),
        .o_out_index    (o_out_index),
        .o_run_done     (o_run_done)
    );

endmodule
